FILE: src/ccc_pkg.sv
// Shared types and constants for the command completeness checker.
package ccc_pkg;

    localparam int DEF_MAX_DEPTH = 255;

    typedef enum logic [1:0] {
        VERDICT_PENDING  = 2'd0,
        VERDICT_COMPLETE = 2'd1,
        VERDICT_ERROR    = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [7:0] char_in;
        logic       restart;
    } t_in;

    typedef struct packed {
        t_verdict   verdict;
        logic [7:0] nesting_depth;
    } t_out;

endpackage

FILE: src/ccc_scanner.sv
// Per-byte scanner state and its next-state logic for the command checker.
module ccc_scanner #(
    parameter int MAX_DEPTH = 255,
    parameter int DEPTH_W   = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  ccc_pkg::t_in  i_data,
    output ccc_pkg::t_out o_result
);
    import ccc_pkg::*;

    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_FF     = 8'h0C;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] PRINT_LO    = 8'h21;
    localparam logic [7:0] PRINT_HI    = 8'h7E;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_STR_ESC = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_BARE    = 3'd4
    } t_mode;

    t_mode               r_mode,        n_mode;
    logic [DEPTH_W-1:0]  r_depth,       n_depth;
    logic                r_token_seen,  n_token_seen;
    logic                r_close_err,   n_close_err;
    t_verdict            r_verdict,     n_verdict;

    logic [7:0]          c;
    logic                is_newline;
    logic                depth_zero;
    t_verdict            end_verdict;
    logic [DEPTH_W+7:0]  depth_wide;

    assign c          = i_data.char_in;
    assign is_newline = (c == CHAR_LF) || (c == CHAR_CR);

    always_comb begin
        // A restart clears everything before the byte is scanned.
        if (i_data.restart) begin
            n_mode       = MODE_NORMAL;
            n_depth      = '0;
            n_token_seen = 1'b0;
            n_close_err  = 1'b0;
            n_verdict    = VERDICT_PENDING;
        end else begin
            n_mode       = r_mode;
            n_depth      = r_depth;
            n_token_seen = r_token_seen;
            n_close_err  = r_close_err;
            n_verdict    = r_verdict;
        end

        depth_zero  = (n_depth == '0);
        end_verdict = n_close_err ? VERDICT_ERROR : VERDICT_COMPLETE;

        // Zero bytes are ignored, and a settled verdict freezes the scan.
        if (c != 8'd0 && n_verdict == VERDICT_PENDING) begin
            unique case (n_mode)
                MODE_STRING: begin
                    if (c == CHAR_BSLASH) begin
                        n_mode = MODE_STR_ESC;
                    end else if (c == CHAR_QUOTE) begin
                        n_mode = MODE_NORMAL;
                        if (depth_zero) begin
                            n_token_seen = 1'b1;
                        end
                    end
                end
                MODE_STR_ESC: begin
                    n_mode = MODE_STRING;
                end
                MODE_COMMENT: begin
                    if (is_newline) begin
                        n_mode = MODE_NORMAL;
                        if (n_token_seen && depth_zero) begin
                            n_verdict = end_verdict;
                        end
                    end
                end
                MODE_BARE: begin
                    if (is_newline) begin
                        n_verdict = end_verdict;
                    end
                end
                default: begin
                    if (is_newline) begin
                        if (n_close_err) begin
                            n_verdict = VERDICT_ERROR;
                        end else if (n_token_seen && depth_zero) begin
                            n_verdict = VERDICT_COMPLETE;
                        end
                    end else if (c == CHAR_SPACE || c == CHAR_FF || c == CHAR_TAB) begin
                        n_mode = n_mode;
                    end else if (c == CHAR_QUOTE) begin
                        n_mode = MODE_STRING;
                    end else if (c == CHAR_SEMI) begin
                        n_mode = MODE_COMMENT;
                    end else if (c == CHAR_LPAREN) begin
                        if (!depth_zero || !n_token_seen) begin
                            if (n_depth < DEPTH_W'(MAX_DEPTH)) begin
                                n_depth = n_depth + DEPTH_W'(1);
                            end
                            n_token_seen = 1'b1;
                        end
                    end else if (c == CHAR_RPAREN) begin
                        if (!depth_zero) begin
                            n_depth = n_depth - DEPTH_W'(1);
                        end else if (!n_token_seen) begin
                            n_close_err = 1'b1;
                        end
                    end else if (depth_zero && c >= PRINT_LO && c <= PRINT_HI) begin
                        n_mode = MODE_BARE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_depth      <= '0;
            r_token_seen <= 1'b0;
            r_close_err  <= 1'b0;
            r_verdict    <= VERDICT_PENDING;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_depth      <= n_depth;
            r_token_seen <= n_token_seen;
            r_close_err  <= n_close_err;
            r_verdict    <= n_verdict;
        end
    end

    // The reported depth is the low byte of the counter, zero-extended if narrower.
    assign depth_wide             = {8'd0, n_depth};
    assign o_result.verdict       = n_verdict;
    assign o_result.nesting_depth = depth_wide[7:0];

endmodule

FILE: src/command_completeness_checker.sv
// Top level of the command completeness checker: handshake and result register.
//
// The block scans a command buffer one byte per request and answers each
// request with exactly one result: a verdict (pending, complete or error)
// and the open parenthesis depth after that byte.
//
// Input channel: i_in_valid / o_in_ready carry i_in_data, which holds the
// byte and a restart flag. A request with restart set clears the scan state
// before its byte is taken as the first byte of a new buffer.
// Output channel: o_out_valid / i_out_ready carry o_out_data.
//
// The scan state and the result register both load at the edge that accepts
// the request, and the result shows in the cycle after. Throughput is one
// request per cycle while the receiver takes each result. The input is ready
// whenever the result register is empty or its content is being taken in the
// same cycle, so a stalled receiver holds the result and stops new requests
// only while it stalls.
//
// A synchronous reset clears the scan state to an empty buffer and empties
// the result register; no results are pending after reset.
module command_completeness_checker #(
    parameter int MAX_DEPTH = ccc_pkg::DEF_MAX_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ccc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ccc_pkg::t_out o_out_data
);
    import ccc_pkg::*;

    // The depth counter is just wide enough to reach MAX_DEPTH.
    localparam int DEPTH_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH + 1) : 1;

    logic  accept;
    logic  r_out_valid;
    t_out  r_out_data;
    t_out  n_out_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    ccc_scanner #(
        .MAX_DEPTH (MAX_DEPTH),
        .DEPTH_W   (DEPTH_W)
    ) u_scanner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_in_data),
        .o_result (n_out_data)
    );

    // Result valid flag: set by a new request, cleared when the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload loads only with a new request, so it holds while stalled.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: src/ccc_checker.sv
// Port-level assertions for the command completeness checker, bound to the top level.
module ccc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input ccc_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ccc_pkg::t_out o_out_data
);
    import ccc_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // The input side is never blocked while the result register is free.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input not ready although result register is free");

    // Every accepted request produces a result on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted request produced no result");

    // A stalled result holds its value.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // Once a verdict is settled, later requests without restart repeat it.
    a_verdict_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in_data.restart && o_out_valid &&
         o_out_data.verdict != VERDICT_PENDING)
        |=> (o_out_data == $past(o_out_data)))
        else $error("settled verdict did not hold");

    // A restart with a zero byte reports an empty, pending buffer.
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.restart && i_in_data.char_in == 8'd0)
        |=> (o_out_data.verdict == VERDICT_PENDING && o_out_data.nesting_depth == 8'd0))
        else $error("restart did not clear the scan state");

endmodule

bind command_completeness_checker ccc_checker u_ccc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
